### rtl/xsr_pkg.sv
// Shared types, constants and decode functions for the crosspoint switch registers.
package xsr_pkg;

    localparam int ROW_COUNT    = 12;
    localparam int COLUMN_COUNT = 8;
    localparam int TABLE_ROWS   = 12;
    localparam int ROW_W        = $clog2(TABLE_ROWS);
    localparam int COL_W        = 3;

    localparam logic [7:0] CLOSE_BIT = 8'h80;

    localparam logic [7:0] READBACK_TABLE [TABLE_ROWS] = '{
        8'h34, 8'h3c, 8'h74, 8'h7c, 8'h35, 8'h3d,
        8'h75, 8'h7d, 8'h36, 8'h3e, 8'h76, 8'h7e
    };

    localparam logic ACTION_WRITE    = 1'b0;
    localparam logic ACTION_READBACK = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] address_byte;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic item_held;
    } t_dp_stat;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_ctrl_state;

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } t_row_sel;

    // Row code 0..5 -> rows 0..5, 8..13 -> rows 6..11; others reserved.
    function automatic t_row_sel decode_row(input logic [3:0] code);
        t_row_sel sel;
        sel.hit = 1'b0;
        sel.row = '0;
        if (code <= 4'd5) begin
            sel.hit = 1'b1;
            sel.row = ROW_W'(code);
        end else if (code >= 4'd8 && code <= 4'd13) begin
            sel.hit = 1'b1;
            sel.row = ROW_W'(code - 4'd2);
        end
        if (sel.hit && (int'(sel.row) >= ROW_COUNT)) begin
            sel.hit = 1'b0;
        end
        return sel;
    endfunction

    // Readback address to row, first match wins.
    function automatic t_row_sel lookup_row(input logic [7:0] addr);
        t_row_sel sel;
        sel.hit = 1'b0;
        sel.row = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (!sel.hit && READBACK_TABLE[r] == addr) begin
                sel.hit = 1'b1;
                sel.row = ROW_W'(r);
            end
        end
        return sel;
    endfunction

endpackage

### rtl/xsr_ctrl.sv
// Controller state machine: accept, execute, strobe the result.
module xsr_ctrl
    import xsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_ctrl_state r_state, n_state;
    logic        r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        busy          = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.item_held) begin
                    o_cmd.execute = 1'b1;
                    n_done        = 1'b1;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

### rtl/xsr_dp.sv
// Datapath: item register, pending and active switch latches, result register.
module xsr_dp
    import xsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_result  o_result
);

    t_item      r_item;
    logic       r_held;
    logic [7:0] r_pending [TABLE_ROWS];
    logic [7:0] r_active  [TABLE_ROWS];
    logic [7:0] n_pending [TABLE_ROWS];
    logic [7:0] n_active  [TABLE_ROWS];
    t_result    r_result, n_result;

    t_row_sel         wr_sel;
    t_row_sel         rd_sel;
    logic [COL_W-1:0] col;
    logic             col_ok;
    logic             wr_ok;
    logic [7:0]       col_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_cmd.capture) begin
            r_held <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        wr_sel  = decode_row(r_item.address_byte[6:3]);
        rd_sel  = lookup_row(r_item.address_byte);
        col     = r_item.address_byte[COL_W-1:0];
        col_ok  = (int'(col) < COLUMN_COUNT);
        wr_ok   = (r_item.action == ACTION_WRITE) && wr_sel.hit && col_ok;
        col_bit = 8'(1) << col;

        n_pending = r_pending;
        n_active  = r_active;
        n_result.read_data = 8'h00;
        n_result.status    = STATUS_REJECTED;

        if (r_item.action == ACTION_READBACK) begin
            if (rd_sel.hit) begin
                n_result.read_data = r_active[rd_sel.row];
                n_result.status    = STATUS_OK;
            end
        end else if (wr_ok) begin
            if ((r_item.address_byte & CLOSE_BIT) != 8'h00) begin
                n_pending[wr_sel.row] = r_pending[wr_sel.row] | col_bit;
            end else begin
                n_pending[wr_sel.row] = r_pending[wr_sel.row] & ~col_bit;
            end
            // load strobe: copy every pending latch into the active switches
            if (r_item.data_byte[0]) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    n_active[r] = n_pending[r];
                end
            end
            n_result.status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < TABLE_ROWS; r++) begin
                r_pending[r] <= 8'h00;
                r_active[r]  <= 8'h00;
            end
        end else if (i_cmd.execute) begin
            r_pending <= n_pending;
            r_active  <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_result <= n_result;
        end
    end

    assign o_stat.item_held = r_held;
    assign o_result         = r_result;

endmodule

### rtl/crosspoint_switch_registers.sv
// Top level of the crosspoint switch register block.
// An item taken at an edge is executed in the next cycle; its result is then
//   registered onto o_result, with o_done high for one cycle.
// The controller's two-state loop takes no new item while one is executing;
//   busy drops while a result strobes, so the next item can overlap it.
// Reset (i_rst_n low, synchronous): all switches open, controller idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module crosspoint_switch_registers
    import xsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    // command and status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    xsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // item register, switch latches and result register
    xsr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule

### sim/crosspoint_switch_registers_tb.sv
// Self-checking testbench for the crosspoint switch register block: random bus accesses vs. a shadow model.
`timescale 1ns / 1ps

module crosspoint_switch_registers_tb;
    import xsr_pkg::*;

    // Run sizing. Slowest correct run is roughly 470 items, each plus its gap,
    // so the limit leaves a wide margin.
    localparam int CYCLE_LIMIT     = 60000;
    localparam int RANDOM_ACCESSES = 450;
    localparam int DRAIN_CYCLES    = 6;

    // Readback address of each row, row 0 first. Kept here on purpose so a
    // wrong table in the RTL shows up as a mismatch.
    localparam logic [7:0] ROW_READ_ADDR [12] = '{
        8'h34, 8'h3c, 8'h74, 8'h7c, 8'h35, 8'h3d,
        8'h75, 8'h7d, 8'h36, 8'h3e, 8'h76, 8'h7e
    };

    // ------------------------------------------------------------------
    // Shadow of the switch matrix: predicts the reply to every accepted
    // bus access and checks the replies in order.
    // ------------------------------------------------------------------
    class xsr_shadow;
        logic [7:0] latched [12];   // pending latches
        logic [7:0] driven  [12];   // switches in force
        t_result    reply_q [$];    // replies still to come, oldest first
        int         mismatches;

        function new();
            foreach (latched[k]) begin
                latched[k] = '0;
                driven[k]  = '0;
            end
            mismatches = 0;
        endfunction

        // Row code to row: 0..5 direct, 8..13 shift down by two, rest reserved.
        function int row_of_code(logic [3:0] code);
            if (code <= 4'd5) return int'(code);
            if (code >= 4'd8 && code <= 4'd13) return int'(code) - 2;
            return -1;
        endfunction

        // Note one accepted item and queue the reply it must produce.
        function void take_access(t_item it);
            t_result    r;
            int         row;
            logic [7:0] mask;
            r.read_data = '0;
            r.status    = STATUS_REJECTED;
            if (it.action == ACTION_READBACK) begin
                for (int k = 0; k < 12; k++) begin
                    if (r.status == STATUS_REJECTED && ROW_READ_ADDR[k] == it.address_byte) begin
                        r.read_data = driven[k];
                        r.status    = STATUS_OK;
                    end
                end
            end else begin
                // Column is 3 bits and decoded rows stop at 11, so only the
                // reserved row codes can reject a write.
                row = row_of_code(it.address_byte[6:3]);
                if (row >= 0) begin
                    mask = 8'h01 << it.address_byte[2:0];
                    if (it.address_byte[7]) latched[row] = latched[row] | mask;
                    else latched[row] = latched[row] & ~mask;
                    if (it.data_byte[0]) driven = latched;
                    r.status = STATUS_OK;
                end
            end
            reply_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one strobed result against the oldest queued reply.
        task match_reply(t_result got);
            t_result want;
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result: read_data %02h status %0b",
                                          got.read_data, got.status));
                return;
            end
            want = reply_q.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %02h, want %02h",
                                          got.read_data, want.read_data));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------
    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_done;
    t_result o_result;

    xsr_shadow shadow;
    int        burst_left;
    int        cycle_count;

    crosspoint_switch_registers DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result side: the block holds each result for one cycle only, so every
    // strobe is taken at the edge that ends it. Values read here are the
    // pre-edge ones, so there is no race with the DUT's own updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) shadow.match_reply(o_result);
    end

    // Watchdog: a hung handshake or a lost result ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drive tasks. All entered right after a rising edge.
    // ------------------------------------------------------------------

    // Present one item and hold it until an edge sees start high and busy low.
    // start stays high on exit so a back-to-back item needs no re-raise.
    task automatic send_access(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        shadow.take_access(it);
    endtask

    // Same, but with bursty pacing: random burst lengths, random gaps, and
    // now and then a long run with no gap at all.
    task automatic send_paced(input t_item it);
        int gap;
        send_access(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_item make_access(logic act, logic [7:0] addr, logic [7:0] data);
        t_item it;
        it.action       = act;
        it.address_byte = addr;
        it.data_byte    = data;
        return it;
    endfunction

    // Random item. Most are well-formed writes or table readbacks so the
    // switch state actually fills up; the rest is raw noise on the bus.
    function automatic t_item random_access();
        t_item      it;
        int         pick;
        logic [3:0] code;
        pick         = $urandom_range(0, 99);
        it.data_byte = 8'($urandom_range(0, 255));
        if (pick < 50) begin
            code = 4'($urandom_range(0, 11));
            if (code > 4'd5) code = code + 4'd2;
            it.action       = ACTION_WRITE;
            it.address_byte = {1'($urandom_range(0, 1)), code, 3'($urandom_range(0, 7))};
            it.data_byte[0] = ($urandom_range(0, 3) == 0);   // load now, sometimes
        end else if (pick < 80) begin
            it.action       = ACTION_READBACK;
            it.address_byte = ROW_READ_ADDR[$urandom_range(0, 11)];
        end else if (pick < 90) begin
            it.action       = ACTION_READBACK;
            it.address_byte = 8'($urandom_range(0, 255));
        end else begin
            it.action       = ACTION_WRITE;
            it.address_byte = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_item directed [$];

        shadow     = new();
        burst_left = 0;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_item    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        directed.push_back(make_access(ACTION_READBACK, 8'h34, 8'h00));  // all open after reset
        directed.push_back(make_access(ACTION_WRITE,    8'h80, 8'hfe));  // close r0 c0, deferred
        directed.push_back(make_access(ACTION_READBACK, 8'h34, 8'h00));  // still open in force
        directed.push_back(make_access(ACTION_WRITE,    8'hef, 8'h01));  // close r11 c7, load
        directed.push_back(make_access(ACTION_READBACK, 8'h34, 8'hff));  // data ignored on read
        directed.push_back(make_access(ACTION_READBACK, 8'h7e, 8'h00));
        directed.push_back(make_access(ACTION_WRITE,    8'hab, 8'h00));  // close r5 c3, deferred
        // reserved row codes, all with the load bit set: nothing may move
        directed.push_back(make_access(ACTION_WRITE,    8'hb0, 8'hff));
        directed.push_back(make_access(ACTION_WRITE,    8'hb8, 8'hff));
        directed.push_back(make_access(ACTION_WRITE,    8'hf0, 8'hff));
        directed.push_back(make_access(ACTION_WRITE,    8'hff, 8'hff));
        directed.push_back(make_access(ACTION_WRITE,    8'h7f, 8'h01));  // code 15, open
        directed.push_back(make_access(ACTION_READBACK, 8'h3d, 8'h00));  // r5 still deferred
        // unknown readback addresses
        directed.push_back(make_access(ACTION_READBACK, 8'h00, 8'h00));
        directed.push_back(make_access(ACTION_READBACK, 8'hff, 8'hff));
        directed.push_back(make_access(ACTION_READBACK, 8'h80, 8'h01));
        directed.push_back(make_access(ACTION_WRITE,    8'h00, 8'h01));  // open r0 c0, load
        directed.push_back(make_access(ACTION_READBACK, 8'h34, 8'h00));
        directed.push_back(make_access(ACTION_READBACK, 8'h3d, 8'h00));  // r5 now in force
        directed.push_back(make_access(ACTION_WRITE,    8'h87, 8'h01));  // r0 c7 close, load
        directed.push_back(make_access(ACTION_READBACK, 8'h34, 8'h00));
        foreach (directed[k]) send_paced(directed[k]);

        // Random part.
        repeat (RANDOM_ACCESSES) send_paced(random_access());

        if (start) start <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (shadow.reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
